// File: rtl/framed_packet_ring_buffer_defines.svh
// -----------------------------------------------------------------------------
// framed_packet_ring_buffer_defines: assertion macros
// Concurrent check wrappers, clocked on i_clk; empty in synthesis builds.
// -----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RING_BUFFER_DEFINES_SVH
`define FRAMED_PACKET_RING_BUFFER_DEFINES_SVH

`ifndef SYNTH
// check that is masked while reset is held
`define FPRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fprb check failed");
// check that also runs through reset
`define FPRB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fprb reset check failed");
`else
`define FPRB_ASSERT(lbl, prop)
`define FPRB_ASSERT_RST(lbl, prop)
`endif

`endif

// File: rtl/fprb_pkg.sv
// -----------------------------------------------------------------------------
// fprb_pkg: shared constants and types
// Ring geometry, field widths, status codes and the result record.
// -----------------------------------------------------------------------------
package fprb_pkg;

    localparam int BUF_BYTES   = 4096;                 // power of two
    localparam int RING_AW     = $clog2(BUF_BYTES);
    localparam int HDR_BYTES   = 12;
    localparam int TOTAL_BYTES = 8;

    localparam int POS_W    = 48;
    localparam int LEN_W    = 12;
    localparam int MARGIN_W = 13;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register word index taken from paddr
    localparam logic REG_READ_MARGIN = 1'b0;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 13'd1024;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       byte_out;
        logic [LEN_W-1:0] length_out;
        logic             last_byte;
        logic [POS_W-1:0] position_out;
        logic [POS_W-1:0] total_written;
    } t_result;

endpackage

// File: rtl/fprb_req_if.sv
// -----------------------------------------------------------------------------
// fprb_req_if: request channel
// Valid/ready channel carrying one write or read item.
// -----------------------------------------------------------------------------
interface fprb_req_if
    import fprb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] packet_length;
    logic [POS_W-1:0] read_position;
    logic [LEN_W-1:0] payload_offset;

    modport source (
        output valid, operation, data_byte, packet_length, read_position,
               payload_offset,
        input  ready
    );
    modport sink (
        input  valid, operation, data_byte, packet_length, read_position,
               payload_offset,
        output ready
    );
endinterface

// File: rtl/fprb_rsp_if.sv
// -----------------------------------------------------------------------------
// fprb_rsp_if: response channel
// Valid/ready channel carrying one read result.
// -----------------------------------------------------------------------------
interface fprb_rsp_if
    import fprb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [7:0]       byte_out;
    logic [LEN_W-1:0] length_out;
    logic             last_byte;
    logic [POS_W-1:0] position_out;
    logic [POS_W-1:0] total_written;

    modport source (
        output valid, status, byte_out, length_out, last_byte, position_out,
               total_written,
        input  ready
    );
    modport sink (
        input  valid, status, byte_out, length_out, last_byte, position_out,
               total_written,
        output ready
    );
endinterface

// File: rtl/framed_packet_ring_buffer.sv
// -----------------------------------------------------------------------------
// framed_packet_ring_buffer: byte ring holding length-framed packets
// Writes frame each packet with a 12-byte header (running total, length);
// reads check reader lag and fetch one payload byte of a framed packet.
// -----------------------------------------------------------------------------
//
//  port     | dir | handshake             | moves
//  ---------+-----+-----------------------+-----------------------------------
//  i_req    | in  | valid/ready           | write byte or read request
//  o_rsp    | out | valid/ready           | one result per read request
//  APB      | in  | psel/penable/pwrite   | read_margin at paddr 0-3
//
//  Write transfer: a continuing payload byte is written at once; the first
//  byte of a packet first writes 12 header bytes through the single memory
//  write port. Read transfer: empty/overrun ends at the lag check, else the
//  4 header length bytes and the payload byte go through the single read port.
//  Reset (sync, active low) clears indexes, totals and handshake state; the
//  ring itself is not cleared and there is no clearing pass.
//  A finished result waits in the output register and a new request is taken;
//  a second one stalls in S_RDONE, blocking requests, till the first completes.
//
`include "framed_packet_ring_buffer_defines.svh"

module framed_packet_ring_buffer
    import fprb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fprb_req_if.sink          i_req,
    fprb_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;  // waiting for a request
    localparam logic [3:0] S_WHDR  = 4'd1;  // writing header bytes
    localparam logic [3:0] S_WPAY  = 4'd2;  // writing the payload byte
    localparam logic [3:0] S_RCHK  = 4'd3;  // lag check
    localparam logic [3:0] S_RLEN  = 4'd4;  // fetching header length bytes
    localparam logic [3:0] S_RLAST = 4'd5;  // last length byte, payload fetch
    localparam logic [3:0] S_RCMP  = 4'd6;  // range check, build result
    localparam logic [3:0] S_RDONE = 4'd7;  // result waits for output slot

    localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);
    localparam logic [1:0] LEN_LAST = 2'd3;

    logic [3:0]          r_state;

    // request fields held while the item is worked on
    logic [7:0]          r_data;
    logic [LEN_W-1:0]    r_len;
    logic [POS_W-1:0]    r_pos;
    logic [LEN_W-1:0]    r_off;

    logic [RING_AW-1:0]  r_widx;
    logic [POS_W-1:0]    r_total;
    logic [LEN_W-1:0]    r_bip;
    logic [MARGIN_W-1:0] r_margin;
    logic [3:0]          r_cnt;
    logic [31:0]         r_len_rd;     // header length, shifted in LSB first

    t_result             r_res;        // finished result, staged
    t_result             n_res;
    t_result             r_out;
    logic                r_out_vld;

    // ring memory
    logic [7:0]          r_ring [BUF_BYTES];
    logic [7:0]          r_rdata;
    logic                mem_we;
    logic [RING_AW-1:0]  mem_waddr;
    logic [7:0]          mem_wdata;
    logic [RING_AW-1:0]  mem_raddr;

    logic                req_xfer;
    logic                out_free;
    logic                cfg_wr;
    logic [POS_W-1:0]    lag;
    logic [POS_W-1:0]    limit;
    logic [LEN_W-1:0]    bip_inc;
    logic                pkt_done;
    logic [7:0]          hdr_byte;

    assign req_xfer = i_req.valid & i_req.ready;
    assign out_free = !r_out_vld || o_rsp.ready;
    assign cfg_wr   = psel & penable & pwrite & pready
                    & (paddr[APB_AW-1] == REG_READ_MARGIN);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_READ_MARGIN)
                  ? APB_DW'(r_margin) : '0;

    // ---------------- header byte select ----------------
    // bytes 0..7: running total (48 bits, top two bytes zero), 8..11: length
    always_comb begin
        case (r_cnt)
            4'd0:    hdr_byte = r_total[7:0];
            4'd1:    hdr_byte = r_total[15:8];
            4'd2:    hdr_byte = r_total[23:16];
            4'd3:    hdr_byte = r_total[31:24];
            4'd4:    hdr_byte = r_total[39:32];
            4'd5:    hdr_byte = r_total[47:40];
            4'd8:    hdr_byte = r_len[7:0];
            4'd9:    hdr_byte = {4'b0, r_len[LEN_W-1:8]};
            default: hdr_byte = 8'd0;
        endcase
    end

    // packet byte count and completion
    assign bip_inc  = r_bip + 1'b1;
    assign pkt_done = (bip_inc == '0) || (bip_inc >= r_len);

    // reader lag; limit saturates at zero for a margin at or above ring size
    assign lag   = r_total - r_pos;
    assign limit = (POS_W'(r_margin) >= POS_W'(BUF_BYTES))
                 ? '0 : POS_W'(BUF_BYTES) - POS_W'(r_margin);

    // ---------------- memory port control ----------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = r_data;
        if (r_state == S_WHDR) begin
            mem_we    = 1'b1;
            mem_waddr = r_widx + RING_AW'(r_cnt);
            mem_wdata = hdr_byte;
        end else if (r_state == S_WPAY) begin
            mem_we    = 1'b1;
        end
        // length bytes at pos+8.., otherwise the wanted payload byte
        if (r_state == S_RLEN) begin
            mem_raddr = r_pos[RING_AW-1:0] + RING_AW'(TOTAL_BYTES)
                      + RING_AW'(r_cnt);
        end else begin
            mem_raddr = r_pos[RING_AW-1:0] + RING_AW'(HDR_BYTES)
                      + RING_AW'(r_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_ring[mem_raddr];
    end

    // ---------------- result build ----------------
    always_comb begin
        n_res               = r_res;
        n_res.position_out  = r_pos;
        n_res.total_written = r_total;
        if (r_state == S_RCHK) begin
            n_res.byte_out   = 8'd0;
            n_res.length_out = '0;
            n_res.last_byte  = 1'b0;
            if (lag == '0) begin
                n_res.status = ST_EMPTY;
            end else begin
                n_res.status       = ST_OVERRUN;
                n_res.position_out = r_total;
            end
        end else begin
            n_res.length_out = r_len_rd[LEN_W-1:0];
            if (32'(r_off) >= r_len_rd) begin
                n_res.status    = ST_RANGE;
                n_res.byte_out  = 8'd0;
                n_res.last_byte = 1'b0;
            end else begin
                n_res.status    = ST_OK;
                n_res.byte_out  = r_rdata;
                n_res.last_byte = (32'(r_off) == (r_len_rd - 32'd1));
            end
        end
    end

    // ---------------- request fields and staged result ----------------
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_data <= i_req.data_byte;
            r_len  <= i_req.packet_length;
            r_pos  <= i_req.read_position;
            r_off  <= i_req.payload_offset;
        end
        if ((r_state == S_RCHK && (lag == '0 || lag > limit))
            || r_state == S_RCMP) begin
            r_res <= n_res;
        end
        if (r_state == S_RLEN || r_state == S_RLAST) begin
            r_len_rd <= {r_rdata, r_len_rd[31:8]};
        end
        if (r_state == S_RDONE && out_free) begin
            r_out <= r_res;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_widx    <= '0;
            r_total   <= '0;
            r_bip     <= '0;
            r_margin  <= MARGIN_RESET;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_margin <= pwdata[MARGIN_W-1:0];
            end
            // a staged result moving in on the same edge keeps valid high
            if (o_rsp.valid && o_rsp.ready && !(r_state == S_RDONE && out_free)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (req_xfer) begin
                        if (i_req.operation == OP_READ) begin
                            r_state <= S_RCHK;
                        end else if (i_req.packet_length != '0) begin
                            // a zero length write is dropped
                            r_state <= (r_bip == '0) ? S_WHDR : S_WPAY;
                        end
                    end
                end
                S_WHDR: begin
                    if (r_cnt == HDR_LAST) begin
                        r_cnt   <= '0;
                        r_widx  <= r_widx + RING_AW'(HDR_BYTES);
                        r_state <= S_WPAY;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_WPAY: begin
                    r_widx <= r_widx + 1'b1;
                    if (pkt_done) begin
                        // 12-bit count wraps to zero at 4096 payload bytes
                        r_total <= r_total + POS_W'({bip_inc == '0, bip_inc})
                                 + POS_W'(HDR_BYTES);
                        r_bip   <= '0;
                    end else begin
                        r_bip <= bip_inc;
                    end
                    r_state <= S_IDLE;
                end
                S_RCHK: begin
                    r_cnt <= '0;
                    if (lag == '0 || lag > limit) begin
                        r_state <= S_RDONE;
                    end else begin
                        r_state <= S_RLEN;
                    end
                end
                S_RLEN: begin
                    // read for byte cnt goes out; byte cnt-1 lands this cycle
                    if (r_cnt[1:0] == LEN_LAST) begin
                        r_state <= S_RLAST;
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
                S_RLAST: begin
                    r_state <= S_RCMP;
                end
                S_RCMP: begin
                    r_state <= S_RDONE;
                end
                S_RDONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- ports ----------------
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.byte_out      = r_out.byte_out;
    assign o_rsp.length_out    = r_out.length_out;
    assign o_rsp.last_byte     = r_out.last_byte;
    assign o_rsp.position_out  = r_out.position_out;
    assign o_rsp.total_written = r_out.total_written;

    // ---------------- checks ----------------
    `FPRB_ASSERT(a_wr_only_in_write, mem_we |-> (r_state == S_WHDR || r_state == S_WPAY))
    `FPRB_ASSERT(a_hdr_then_payload, (r_state == S_WHDR && r_cnt == HDR_LAST) |=> (r_state == S_WPAY))
    `FPRB_ASSERT(a_hdr_cnt_range, (r_state == S_WHDR) |-> (r_cnt <= HDR_LAST))
    `FPRB_ASSERT(a_done_blocks_req, (r_state == S_RDONE && !out_free) |=> (r_state == S_RDONE && !i_req.ready))
    `FPRB_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_rsp.valid && r_bip == '0))

endmodule

// File: tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench: framed_packet_ring_buffer
// Checks packet framing, payload reads and reader lag status against a cycle-
// free model of the ring, across several read_margin settings and ring wrap.
// -----------------------------------------------------------------------------
module testbench
    import fprb_pkg::*;
();

    // longest legal quiet spell is a header write plus sender gap and a few
    // response stalls; this is that many times over
    localparam int WATCHDOG_LIMIT = 4000;
    // a write of a packet's first byte occupies the block for its header and payload writes
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_ITEMS    = 10;
    localparam int LOG_DEPTH      = 32;
    localparam logic [APB_AW-1:0] MARGIN_ADDR = {REG_READ_MARGIN, 2'b00};

    typedef struct {
        logic             op;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] off;
    } t_ring_req;

    // completed packet as seen in the stream
    typedef struct {
        logic [POS_W-1:0] start;
        logic [31:0]      hdr_len;
        int unsigned      count;
    } t_packet_rec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    fprb_req_if req_ch ();
    fprb_rsp_if rsp_ch ();

    framed_packet_ring_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ring image and stream state
    logic [7:0]          ring_image   [BUF_BYTES];
    bit                  ring_written [BUF_BYTES];
    logic [RING_AW-1:0]  wr_index;
    logic [POS_W-1:0]    stream_total;
    logic [LEN_W-1:0]    pkt_bytes;
    logic [31:0]         pkt_hdr_len;
    logic [MARGIN_W-1:0] margin_reg;

    t_packet_rec packet_log[$];
    t_result     pending_results[$];

    // packet generator state: declared header length, bytes actually sent
    logic [LEN_W-1:0] gen_decl;
    int unsigned      gen_actual;

    bit req_idle_en;
    bit rsp_idle_en;
    int error_count;
    int quiet_cycles;

    function automatic void store_byte(logic [RING_AW-1:0] idx, logic [7:0] b);
        ring_image[idx]   = b;
        ring_written[idx] = 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] overrun_limit();
        if (margin_reg >= BUF_BYTES)
            return '0;
        return POS_W'(BUF_BYTES - margin_reg);
    endfunction

    function automatic logic [31:0] stored_length(logic [POS_W-1:0] pos);
        logic [31:0] v;
        int i;
        for (i = 0; i < 4; i++)
            v[8*i +: 8] = ring_image[RING_AW'(pos[RING_AW-1:0] + TOTAL_BYTES + i)];
        return v;
    endfunction

    // header on a packet's first byte, payload byte, total bump on completion
    function automatic void advance_ring_write(logic [7:0] b, logic [LEN_W-1:0] len);
        logic [31:0] hdr_word;
        logic [63:0] total_word;
        int unsigned n;
        t_packet_rec rec;
        int i;
        if (len == 0)
            return;
        if (pkt_bytes == 0) begin
            hdr_word   = 32'(len);
            // 48-bit total stored as 8 bytes, top two zero
            total_word = 64'(stream_total);
            for (i = 0; i < TOTAL_BYTES; i++)
                store_byte(wr_index + RING_AW'(i), total_word[8*i +: 8]);
            for (i = 0; i < 4; i++)
                store_byte(wr_index + RING_AW'(TOTAL_BYTES + i), hdr_word[8*i +: 8]);
            pkt_hdr_len = hdr_word;
            wr_index    = wr_index + RING_AW'(HDR_BYTES);
        end
        store_byte(wr_index, b);
        wr_index  = wr_index + 1'b1;
        pkt_bytes = pkt_bytes + 1'b1;
        // completes on the current length, not the one in the header
        if (pkt_bytes == 0 || pkt_bytes >= len) begin
            n = (pkt_bytes == 0) ? BUF_BYTES : pkt_bytes;
            rec.start   = stream_total;
            rec.hdr_len = pkt_hdr_len;
            rec.count   = n;
            packet_log.push_back(rec);
            if (packet_log.size() > LOG_DEPTH)
                void'(packet_log.pop_front());
            stream_total = stream_total + POS_W'(n + HDR_BYTES);
            pkt_bytes    = '0;
        end
    endfunction

    function automatic t_result predict_read_result(logic [POS_W-1:0] pos,
                                                    logic [LEN_W-1:0] off);
        t_result res;
        logic [POS_W-1:0] lag;
        logic [31:0] hdr;
        res = '0;
        res.position_out  = pos;
        res.total_written = stream_total;
        lag = stream_total - pos;
        if (lag == 0) begin
            res.status = ST_EMPTY;
        end else if (lag > overrun_limit()) begin
            res.status       = ST_OVERRUN;
            res.position_out = stream_total;
        end else begin
            hdr = stored_length(pos);
            res.length_out = hdr[LEN_W-1:0];
            if (32'(off) >= hdr) begin
                res.status = ST_RANGE;
            end else begin
                res.status    = ST_OK;
                res.byte_out  = ring_image[RING_AW'(pos[RING_AW-1:0] + HDR_BYTES + off)];
                res.last_byte = (32'(off) == hdr - 1);
            end
        end
        return res;
    endfunction

    // a read that would fetch a ring entry never written
    function automatic bit read_touches_blank(logic [POS_W-1:0] pos,
                                              logic [LEN_W-1:0] off);
        logic [POS_W-1:0] lag;
        int i;
        lag = stream_total - pos;
        if (lag == 0 || lag > overrun_limit())
            return 1'b0;
        for (i = 0; i < 4; i++)
            if (!ring_written[RING_AW'(pos[RING_AW-1:0] + TOTAL_BYTES + i)])
                return 1'b1;
        if (32'(off) >= stored_length(pos))
            return 1'b0;
        return !ring_written[RING_AW'(pos[RING_AW-1:0] + HDR_BYTES + off)];
    endfunction

    // unused fields get random values so every bit toggles
    function automatic t_ring_req write_item(logic [7:0] b, logic [LEN_W-1:0] len);
        t_ring_req it;
        it.op   = OP_WRITE;
        it.data = b;
        it.len  = len;
        it.pos  = POS_W'({$urandom(), $urandom()});
        it.off  = LEN_W'($urandom());
        return it;
    endfunction

    function automatic t_ring_req read_item(logic [POS_W-1:0] pos, logic [LEN_W-1:0] off);
        t_ring_req it;
        it.op   = OP_READ;
        it.data = 8'($urandom());
        it.len  = LEN_W'($urandom());
        it.pos  = read_touches_blank(pos, off) ? stream_total : pos;
        it.off  = off;
        return it;
    endfunction

    function automatic t_ring_req random_read();
        t_packet_rec rec;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] off;
        int unsigned c;
        c   = $urandom_range(99);
        pos = stream_total;
        off = LEN_W'($urandom_range(0, 4083));
        if (packet_log.size() != 0 && c < 61) begin
            rec = packet_log[$urandom_range(0, packet_log.size() - 1)];
            pos = rec.start;
            if (c < 45)
                off = LEN_W'($urandom_range(0, rec.count - 1));
            else if (c < 53)
                off = LEN_W'(rec.hdr_len - 1);
            else if (rec.hdr_len >= 4083)
                off = LEN_W'(4083);
            else
                off = LEN_W'($urandom_range(rec.hdr_len, 4083));
        end else if (c < 69) begin
            pos = stream_total;
        end else if (c < 79) begin
            pos = POS_W'({$urandom(), $urandom()});
        end else if (c < 89) begin
            // right at the overrun boundary
            pos = stream_total - overrun_limit() - POS_W'($urandom_range(0, 1));
        end else begin
            pos = stream_total - POS_W'($urandom_range(1, 4200));
        end
        return read_item(pos, off);
    endfunction

    // one request transfer; model updated on acceptance
    task automatic transfer_request(input t_ring_req it);
        @(negedge i_clk);
        if (req_idle_en && $urandom_range(99) < 28) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        req_ch.operation      = it.op;
        req_ch.data_byte      = it.data;
        req_ch.packet_length  = it.len;
        req_ch.read_position  = it.pos;
        req_ch.payload_offset = it.off;
        req_ch.valid          = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        if (it.op == OP_WRITE)
            advance_ring_write(it.data, it.len);
        else
            pending_results.push_back(predict_read_result(it.pos, it.off));
    endtask

    task automatic send_packet_byte(input bit single_only);
        int unsigned c;
        logic [LEN_W-1:0] len;
        if (pkt_bytes == 0) begin
            c = $urandom_range(99);
            if (single_only) begin
                gen_decl   = LEN_W'(1);
                gen_actual = 1;
            end else if (c < 55) begin
                gen_decl   = LEN_W'($urandom_range(1, 6));
                gen_actual = gen_decl;
            end else if (c < 85) begin
                gen_decl   = LEN_W'($urandom_range(7, 40));
                gen_actual = gen_decl;
            end else begin
                // long header length, cut short by lowering the length
                gen_decl   = LEN_W'($urandom_range(41, 4084));
                gen_actual = $urandom_range(2, 8);
            end
        end
        len = (pkt_bytes + 1 == gen_actual) ? LEN_W'(gen_actual) : gen_decl;
        transfer_request(write_item(8'($urandom()), len));
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // APB write then read back, only with the block idle
    task automatic program_margin(input logic [MARGIN_W-1:0] value);
        drain_requests();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MARGIN_ADDR;
        pwdata  = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        margin_reg = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("read_margin", POS_W'(margin_reg), POS_W'(prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_directed_framing();
        logic [POS_W-1:0] pkt_start;
        transfer_request(read_item('0, '0));                      // nothing written
        transfer_request(read_item(48'h8000_0000_0000, 12'd4083)); // far behind
        transfer_request(write_item(8'hFF, '0));                  // zero length, ignored
        transfer_request(write_item(8'h00, 12'd3));
        transfer_request(write_item(8'hFF, 12'd3));
        transfer_request(write_item(8'h5A, 12'd3));
        transfer_request(read_item('0, 12'd0));
        transfer_request(read_item('0, 12'd2));                   // final byte
        transfer_request(read_item('0, 12'd3));                   // just past the end
        transfer_request(read_item('0, 12'd4083));
        transfer_request(read_item(stream_total, '0));            // caught up
        // header says 4084, length drops to 2 on the second byte
        pkt_start = stream_total;
        transfer_request(write_item(8'hC3, 12'd4084));
        transfer_request(write_item(8'h3C, 12'd2));
        transfer_request(read_item(pkt_start, 12'd1));
        transfer_request(read_item(pkt_start, 12'd4083));         // wraps the ring
        transfer_request(read_item('1, '0));                      // lag wraps 48 bits
        // length raised mid-packet: packet runs on to the new length
        pkt_start = stream_total;
        transfer_request(write_item(8'h81, 12'd2));
        transfer_request(write_item(8'h7E, 12'd5));
        transfer_request(write_item(8'h01, 12'd5));
        transfer_request(write_item(8'hFE, 12'd5));
        transfer_request(write_item(8'h80, 12'd5));
        transfer_request(read_item(pkt_start, 12'd4));
        transfer_request(read_item(pkt_start, 12'd1));
    endtask

    // single-byte packets move 13 bytes each, so the ring turns over quickly;
    // both sides run flat out here
    task automatic test_ring_wrap();
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        while (stream_total < BUF_BYTES + 128) begin
            if ($urandom_range(99) < 85)
                send_packet_byte(1'b1);
            else
                transfer_request(random_read());
        end
        req_idle_en = 1'b1;
        rsp_idle_en = 1'b1;
    endtask

    task automatic test_margin_extremes();
        logic [MARGIN_W-1:0] margins [4];
        int k;
        margins = '{13'd4096, 13'd4095, 13'd0, 13'd1};
        for (k = 0; k < 4; k++) begin
            program_margin(margins[k]);
            transfer_request(read_item(packet_log[$].start, '0));
            repeat (4) transfer_request(random_read());
        end
    endtask

    task automatic test_random_traffic();
        logic [MARGIN_W-1:0] margins [3];
        int k;
        int n;
        int unsigned c;
        margins = '{MARGIN_RESET, MARGIN_W'($urandom_range(0, 4096)), 13'd2048};
        for (k = 0; k < 3; k++) begin
            program_margin(margins[k]);
            n = 0;
            while (n < PHASE_ITEMS) begin
                c = $urandom_range(99);
                if (c < 4) begin
                    transfer_request(write_item(8'($urandom()), '0));
                end else if (c < 54) begin
                    send_packet_byte(1'b0);
                    n++;
                end else begin
                    transfer_request(random_read());
                    n++;
                end
            end
        end
    endtask

    // response sink, random back-pressure
    always @(negedge i_clk)
        rsp_ch.ready <= !(rsp_idle_en && $urandom_range(99) < 28);

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, rsp_ch.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("byte_out", want.byte_out, rsp_ch.byte_out);
                check_field("length_out", want.length_out, rsp_ch.length_out);
                check_field("last_byte", want.last_byte, rsp_ch.last_byte);
                check_field("position_out", want.position_out, rsp_ch.position_out);
                check_field("total_written", want.total_written, rsp_ch.total_written);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_WRITE;
        req_ch.data_byte      = '0;
        req_ch.packet_length  = '0;
        req_ch.read_position  = '0;
        req_ch.payload_offset = '0;
        rsp_ch.ready          = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        wr_index              = '0;
        stream_total          = '0;
        pkt_bytes             = '0;
        pkt_hdr_len           = '0;
        margin_reg            = MARGIN_RESET;
        gen_decl              = '0;
        gen_actual            = 0;
        req_idle_en           = 1'b1;
        rsp_idle_en           = 1'b1;
        error_count           = 0;
        quiet_cycles          = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_framing();
        test_ring_wrap();
        test_margin_extremes();
        test_random_traffic();

        drain_requests();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
